[rtl/raa_pkg.sv]
`default_nettype none

package raa_pkg;

	localparam int unsigned IN_W              = 16;
	localparam int unsigned ANG_W             = 16;
	localparam int unsigned XW                = 56;
	localparam int unsigned AW                = 34;
	localparam int unsigned MW                = 53;
	localparam int unsigned ATAN_LEN          = 24;
	localparam int unsigned CORDIC_STAGES_DEF = 16;

	// Arctangent of 2^-i in binary angle units, a full turn being 2^32.
	localparam logic signed [AW-1:0] ATAN_BAM [ATAN_LEN] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
		34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
		34'sd652,       34'sd326,       34'sd163,       34'sd81
	};

	localparam logic signed [AW-1:0]    HALF_TURN = 34'sd2147483648;
	localparam logic signed [31:0]      PI_Q29    = 32'sd1686629713;
	localparam logic signed [ANG_W-1:0] ANGLE_MAX = 16'sd25736;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [AW-1:0] acc;
		logic                 zero;
	} raa_vec_t;

endpackage

`default_nettype wire

[rtl/raa_if.sv]
`default_nettype none

interface raa_in_if import raa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic signed [IN_W-1:0] r00;
	logic signed [IN_W-1:0] r01;
	logic signed [IN_W-1:0] r02;
	logic signed [IN_W-1:0] r10;
	logic signed [IN_W-1:0] r11;
	logic signed [IN_W-1:0] r12;
	logic signed [IN_W-1:0] r20;
	logic signed [IN_W-1:0] r21;
	logic signed [IN_W-1:0] r22;
	logic signed [IN_W-1:0] ax;
	logic signed [IN_W-1:0] ay;
	logic signed [IN_W-1:0] az;

	modport source (
		output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, ax, ay, az,
		input  ready
	);
	modport sink (
		input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, ax, ay, az,
		output ready
	);
endinterface

interface raa_out_if import raa_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ANG_W-1:0] angle;

	modport source (output valid, angle, input ready);
	modport sink (input valid, angle, output ready);
endinterface

`default_nettype wire

[rtl/rotation_angle_about_axis.sv]
// Throughput: one beat per cycle while result.ready does not stall the pipeline; every
// stage is a register stage and one CORDIC rotation is one stage, so the pipeline depth
// is set by the CORDIC stage count.
// Each stage holds while the one after it is full and stalled, so bubbles close up.
// Reset (arst_n low) clears every valid bit asynchronously; data registers are not reset.
`default_nettype none

module rotation_angle_about_axis import raa_pkg::*; #(
	parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	raa_in_if.sink    pose,
	raa_out_if.source result
);

	localparam int unsigned NST = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

	raa_vec_t front_vec;
	logic     front_valid, front_ready;

	raa_vec_t cv     [NST+1];
	logic     cvalid [NST+1];
	logic     cready [NST+1];

	raa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pose      (pose),
		.out_vec   (front_vec),
		.out_valid (front_valid),
		.out_ready (front_ready)
	);

	raa_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vec    (front_vec),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.out_vec   (cv[0]),
		.out_valid (cvalid[0]),
		.out_ready (cready[0])
	);

	for (genvar i = 0; i < NST; i++) begin : g_cordic
		raa_cordic_stage #(
			.IDX (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_vec    (cv[i]),
			.in_valid  (cvalid[i]),
			.in_ready  (cready[i]),
			.out_vec   (cv[i+1]),
			.out_valid (cvalid[i+1]),
			.out_ready (cready[i+1])
		);
	end

	raa_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vec   (cv[NST]),
		.in_valid (cvalid[NST]),
		.in_ready (cready[NST]),
		.result   (result)
	);

endmodule

`default_nettype wire

[rtl/raa_front.sv]
`default_nettype none

module raa_front import raa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	raa_in_if.sink    pose,
	output raa_vec_t  out_vec,
	output logic      out_valid,
	input  wire logic out_ready
);

	localparam int unsigned DW  = IN_W + 1;
	localparam int unsigned TW  = IN_W + 2;
	localparam int unsigned PW  = 2 * IN_W;
	localparam int unsigned QPW = 48;
	localparam int unsigned SPW = 33;
	localparam int unsigned QSW = 50;
	localparam int unsigned SSW = 34;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic signed [DW-1:0]   d0_s1, d1_s1, d2_s1, e0_s1, e1_s1, e2_s1;
	logic signed [TW-1:0]   tr_s1, tr_s2, tr_s3;
	logic signed [IN_W-1:0] r00_s1, r11_s1, r22_s1, ax_s1, ay_s1, az_s1;
	logic signed [PW-1:0]   pxx_s1, pyy_s1, pzz_s1, pxy_s1, pxz_s1, pyz_s1;

	logic signed [QPW-1:0] qp0_s2, qp1_s2, qp2_s2, qp3_s2, qp4_s2, qp5_s2;
	logic signed [SPW-1:0] sp0_s2, sp1_s2, sp2_s2;

	logic signed [QSW-1:0] qa_s3, qb_s3;
	logic signed [SSW-1:0] ss_s3;

	raa_vec_t vec_s4;

	assign en_s4 = !v_s4 || out_ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign pose.ready = en_s1;
	assign out_valid  = v_s4;
	assign out_vec    = vec_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pose.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: entry differences and sums, trace and axis products.
	always_ff @(posedge clk) begin
		if (en_s1 && pose.valid) begin
			d0_s1  <= DW'(pose.r21) - DW'(pose.r12);
			d1_s1  <= DW'(pose.r02) - DW'(pose.r20);
			d2_s1  <= DW'(pose.r10) - DW'(pose.r01);
			e0_s1  <= DW'(pose.r10) + DW'(pose.r01);
			e1_s1  <= DW'(pose.r20) + DW'(pose.r02);
			e2_s1  <= DW'(pose.r21) + DW'(pose.r12);
			tr_s1  <= TW'(pose.r00) + TW'(pose.r11) + TW'(pose.r22);
			r00_s1 <= pose.r00;
			r11_s1 <= pose.r11;
			r22_s1 <= pose.r22;
			ax_s1  <= pose.ax;
			ay_s1  <= pose.ay;
			az_s1  <= pose.az;
			pxx_s1 <= PW'(pose.ax) * PW'(pose.ax);
			pyy_s1 <= PW'(pose.ay) * PW'(pose.ay);
			pzz_s1 <= PW'(pose.az) * PW'(pose.az);
			pxy_s1 <= PW'(pose.ax) * PW'(pose.ay);
			pxz_s1 <= PW'(pose.ax) * PW'(pose.az);
			pyz_s1 <= PW'(pose.ay) * PW'(pose.az);
		end
	end

	// Stage 2: the terms of the quadratic form and of the cross term.
	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			qp0_s2 <= QPW'(pxx_s1) * QPW'(r00_s1);
			qp1_s2 <= QPW'(pyy_s1) * QPW'(r11_s1);
			qp2_s2 <= QPW'(pzz_s1) * QPW'(r22_s1);
			qp3_s2 <= QPW'(pxy_s1) * QPW'(e0_s1);
			qp4_s2 <= QPW'(pxz_s1) * QPW'(e1_s1);
			qp5_s2 <= QPW'(pyz_s1) * QPW'(e2_s1);
			sp0_s2 <= SPW'(ax_s1) * SPW'(d0_s1);
			sp1_s2 <= SPW'(ay_s1) * SPW'(d1_s1);
			sp2_s2 <= SPW'(az_s1) * SPW'(d2_s1);
			tr_s2  <= tr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			qa_s3 <= QSW'(qp0_s2) + QSW'(qp1_s2) + QSW'(qp2_s2);
			qb_s3 <= QSW'(qp3_s2) + QSW'(qp4_s2) + QSW'(qp5_s2);
			ss_s3 <= SSW'(sp0_s2) + SSW'(sp1_s2) + SSW'(sp2_s2);
			tr_s3 <= tr_s2;
		end
	end

	// Stage 4: both arctangent arguments at the common Q.42 scale.
	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			vec_s4.x    <= (XW'(tr_s3) <<< 28) - XW'(qa_s3) - XW'(qb_s3);
			vec_s4.y    <= -(XW'(ss_s3) <<< 14);
			vec_s4.acc  <= '0;
			vec_s4.zero <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[rtl/raa_norm.sv]
`default_nettype none

module raa_norm import raa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  raa_vec_t  in_vec,
	input  wire logic in_valid,
	output logic      in_ready,
	output raa_vec_t  out_vec,
	output logic      out_valid,
	input  wire logic out_ready
);

	typedef struct packed {
		raa_vec_t        v;
		logic [MW-1:0]   m;
	} raa_nrm_t;

	// Three steps of the leading-zero search, halving the shift each time.
	function automatic raa_nrm_t norm_steps(raa_nrm_t a, int unsigned first);
		raa_nrm_t    r;
		int unsigned sh;
		r = a;
		for (int unsigned j = 0; j < 3; j++) begin
			sh = first >> j;
			if ((r.m >> (MW - sh)) == '0) begin
				r.m   = r.m << sh;
				r.v.x = r.v.x <<< sh;
				r.v.y = r.v.y <<< sh;
			end
		end
		return r;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	raa_vec_t vec_s1, vec_s2;
	logic [MW-1:0] m_s2;
	raa_nrm_t nrm_s3, nrm_s4;

	logic [MW-1:0] xa, ya;
	raa_nrm_t a3, a4;

	assign en_s4 = !v_s4 || out_ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign in_ready  = en_s1;
	assign out_valid = v_s4;
	assign out_vec   = nrm_s4.v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// A vector in the left half-plane is turned by half a turn first.
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			vec_s1.zero <= (in_vec.x == '0) && (in_vec.y == '0);
			if (in_vec.x < 0) begin
				vec_s1.x   <= -in_vec.x;
				vec_s1.y   <= -in_vec.y;
				vec_s1.acc <= (in_vec.y < 0) ? -HALF_TURN : HALF_TURN;
			end else begin
				vec_s1.x   <= in_vec.x;
				vec_s1.y   <= in_vec.y;
				vec_s1.acc <= '0;
			end
		end
	end

	always_comb begin
		xa = MW'(vec_s1.x);
		ya = (vec_s1.y < 0) ? MW'(-vec_s1.y) : MW'(vec_s1.y);
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			vec_s2 <= vec_s1;
			m_s2   <= (xa > ya) ? xa : ya;
		end
	end

	always_comb begin
		a3 = norm_steps('{v: vec_s2, m: m_s2}, 32);
		a4 = norm_steps(nrm_s3, 4);
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) nrm_s3 <= a3;
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) nrm_s4 <= a4;
	end

endmodule

`default_nettype wire

[rtl/raa_cordic_stage.sv]
`default_nettype none

module raa_cordic_stage import raa_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  raa_vec_t  in_vec,
	input  wire logic in_valid,
	output logic      in_ready,
	output raa_vec_t  out_vec,
	output logic      out_valid,
	input  wire logic out_ready
);

	logic     v_s1;
	logic     en_s1;
	raa_vec_t vec_s1;
	raa_vec_t nxt;
	logic signed [XW-1:0] xs, ys;

	assign en_s1     = !v_s1 || out_ready;
	assign in_ready  = en_s1;
	assign out_valid = v_s1;
	assign out_vec   = vec_s1;

	// Rotate towards the x axis; the sign of y picks the direction.
	always_comb begin
		xs  = in_vec.x >>> IDX;
		ys  = in_vec.y >>> IDX;
		nxt = in_vec;
		if (!in_vec.y[XW-1]) begin
			nxt.x   = in_vec.x + ys;
			nxt.y   = in_vec.y - xs;
			nxt.acc = in_vec.acc + ATAN_BAM[IDX];
		end else begin
			nxt.x   = in_vec.x - ys;
			nxt.y   = in_vec.y + xs;
			nxt.acc = in_vec.acc - ATAN_BAM[IDX];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) vec_s1 <= nxt;
	end

endmodule

`default_nettype wire

[rtl/raa_out.sv]
`default_nettype none

module raa_out import raa_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  raa_vec_t   in_vec,
	input  wire logic  in_valid,
	output logic       in_ready,
	raa_out_if.source  result
);

	localparam int unsigned LO_W   = 17;
	localparam int unsigned HI_W   = AW - LO_W;
	localparam int unsigned PROD_W = 49;
	localparam int unsigned SUM_W  = 66;
	localparam int unsigned RQ_W   = 19;

	logic v_s1, v_s2;
	logic en_s1, en_s2;

	logic signed [PROD_W-1:0] phi_s1, plo_s1;
	logic                     zero_s1;
	logic signed [ANG_W-1:0]  angle_s2;

	logic signed [HI_W-1:0]  ah;
	logic        [LO_W-1:0]  al;
	logic signed [SUM_W-1:0] sum;
	logic signed [RQ_W-1:0]  rq;
	logic signed [ANG_W-1:0] ang;

	assign en_s2 = !v_s2 || result.ready;
	assign en_s1 = !v_s1 || en_s2;

	assign in_ready     = en_s1;
	assign result.valid = v_s2;
	assign result.angle = angle_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	// The accumulator times pi is split into two partial products.
	always_comb begin
		ah = in_vec.acc[AW-1:LO_W];
		al = in_vec.acc[LO_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			phi_s1  <= PROD_W'(ah) * PROD_W'(PI_Q29);
			plo_s1  <= PROD_W'($signed({1'b0, al})) * PROD_W'(PI_Q29);
			zero_s1 <= in_vec.zero;
		end
	end

	// Round to nearest, halves up, then clamp to +-pi; a zero vector gives 0.
	always_comb begin
		sum = (SUM_W'(phi_s1) <<< LO_W) + SUM_W'(plo_s1) + (SUM_W'(1) <<< 46);
		rq  = RQ_W'(sum >>> 47);
		if (zero_s1) begin
			ang = '0;
		end else if (rq > RQ_W'(ANGLE_MAX)) begin
			ang = ANGLE_MAX;
		end else if (rq < -RQ_W'(ANGLE_MAX)) begin
			ang = -ANGLE_MAX;
		end else begin
			ang = ANG_W'(rq);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) angle_s2 <= ang;
	end

endmodule

`default_nettype wire

[tb/sv/rotation_angle_about_axis_test.sv]
`default_nettype none

module rotation_angle_about_axis_test import raa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES          = CORDIC_STAGES_DEF;
	localparam int RUN_STAGES      = (STAGES > 24) ? 24 : STAGES;
	localparam int LATENCY         = STAGES + 10;
	localparam int DRAIN_CYCLES    = 2 * LATENCY + 20;
	localparam int N_RANDOM        = 1780;
	localparam int CALM_TAIL       = 150;
	localparam int HOLD_OFF_CYCLES = 240;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int MAX_REPORTS     = 10;

	localparam int ONE = 16384;
	localparam int MX  = 32767;
	localparam int MN  = -32768;
	localparam int C45 = 11585;
	localparam int A3  = 9459;

	// How the expected angle of a directed row is obtained.
	localparam int PREDICTED = 0;
	localparam int TYPED     = 1;

	localparam longint HALF_TURN  = 64'sd2147483648;
	localparam longint NORM_FLOOR = 64'sd1 << 52;
	localparam longint PI_Q2_29   = 64'sd1686629713;
	localparam longint ROUND_BIAS = 64'sd1 << 46;
	localparam longint PI_LIMIT   = 64'sd25736;

	// atan(2^-i) with a full turn being 2^32.
	localparam longint TURN_STEP [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef struct packed {
		logic signed [IN_W-1:0] r00, r01, r02;
		logic signed [IN_W-1:0] r10, r11, r12;
		logic signed [IN_W-1:0] r20, r21, r22;
		logic signed [IN_W-1:0] ax, ay, az;
	} pose_t;

	localparam int N_DIRECTED = 24;
	// r00 r01 r02 r10 r11 r12 r20 r21 r22 ax ay az, then how the angle is found, then angle.
	localparam int DIRECTED [N_DIRECTED][14] = '{
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, TYPED, 0},
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, MX, MN, ONE, TYPED, 0},
		'{ONE, 0, 0, 0, -ONE, 0, 0, 0, 0, 0, 0, 0, TYPED, 0},
		'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, 0, 0, PREDICTED, 0},
		'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, 0, PREDICTED, 0},
		'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE, PREDICTED, 0},
		'{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE, 0, 0, ONE, PREDICTED, 0},
		'{0, ONE, 0, -ONE, 0, 0, 0, 0, ONE, 0, 0, ONE, PREDICTED, 0},
		'{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE, 0, 0, ONE, PREDICTED, 0},
		'{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, ONE, 0, 0, PREDICTED, 0},
		'{-ONE, -1, 0, 1, -ONE, 0, 0, 0, ONE, 0, 0, ONE, PREDICTED, 0},
		'{MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, PREDICTED, 0},
		'{MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, PREDICTED, 0},
		'{MX, MX, MX, MX, MX, MX, MX, MX, MX, MN, MN, MN, PREDICTED, 0},
		'{MN, MN, MN, MN, MN, MN, MN, MN, MN, MX, MX, MX, PREDICTED, 0},
		'{MX, MN, MX, MN, MX, MN, MX, MN, MX, MN, MX, MN, PREDICTED, 0},
		'{21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845,
		  -21846, 21845, -21846, PREDICTED, 0},
		'{0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0, PREDICTED, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PREDICTED, 0},
		'{-1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PREDICTED, 0},
		'{C45, -C45, 0, C45, C45, 0, 0, 0, ONE, 0, 0, ONE, PREDICTED, 0},
		'{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE, 0, 0, MX, PREDICTED, 0},
		'{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, PREDICTED, 0},
		'{0, 0, ONE, ONE, 0, 0, 0, ONE, 0, A3, A3, A3, PREDICTED, 0}
	};

	logic clk;
	logic arst_n;

	raa_in_if  pose_bus ();
	raa_out_if angle_bus ();

	rotation_angle_about_axis #(.CORDIC_STAGES(STAGES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pose   (pose_bus),
		.result (angle_bus)
	);

	logic signed [ANG_W-1:0] pending_angles [$];
	int  mismatches;
	int  angles_checked;
	int  poses_sent;
	int  rotations_sent;
	int  at_pi_limit;
	int  quiet_cycles;
	bit  calm;
	bit  held_off;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// atan2(-s, trace - a'Ra) in Q3.13, with the vectoring CORDIC done bit for bit.
	function automatic logic signed [ANG_W-1:0] angle_about_axis(pose_t p);
		longint r00, r01, r02, r10, r11, r12, r20, r21, r22, ax, ay, az;
		longint s, q, tr, x, y, acc, m, xs, ys, r;
		int i;
		r00 = p.r00; r01 = p.r01; r02 = p.r02;
		r10 = p.r10; r11 = p.r11; r12 = p.r12;
		r20 = p.r20; r21 = p.r21; r22 = p.r22;
		ax = p.ax; ay = p.ay; az = p.az;
		s = ax * (r21 - r12) + ay * (r02 - r20) + az * (r10 - r01);
		q = (ax * ax) * r00 + (ay * ay) * r11 + (az * az) * r22
		  + (ax * ay) * (r10 + r01) + (ax * az) * (r20 + r02)
		  + (ay * az) * (r21 + r12);
		tr = r00 + r11 + r22;
		y = -s * 16384;
		x = tr * 268435456 - q;
		if (x == 0 && y == 0)
			return '0;
		acc = 0;
		// A vector in the left half-plane is turned through half a turn first.
		if (x < 0) begin
			acc = (y < 0) ? -HALF_TURN : HALF_TURN;
			x = -x;
			y = -y;
		end
		m = (x > ((y < 0) ? -y : y)) ? x : ((y < 0) ? -y : y);
		while (m < NORM_FLOOR) begin
			m = m * 2;
			x = x * 2;
			y = y * 2;
		end
		for (i = 0; i < RUN_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				acc = acc + TURN_STEP[i];
			end else begin
				x = x - ys;
				y = y + xs;
				acc = acc - TURN_STEP[i];
			end
		end
		r = (acc * PI_Q2_29 + ROUND_BIAS) >>> 47;
		if (r > PI_LIMIT)
			r = PI_LIMIT;
		if (r < -PI_LIMIT)
			r = -PI_LIMIT;
		return ANG_W'(r);
	endfunction

	function automatic real uniform_pm1();
		return (real'($urandom) / 4294967295.0) * 2.0 - 1.0;
	endfunction

	function automatic logic signed [IN_W-1:0] to_q2_14(real v);
		real t;
		t = v * 16384.0;
		t = (t >= 0.0) ? t + 0.5 : t - 0.5;
		if (t > 32767.0)
			t = 32767.0;
		if (t < -32768.0)
			t = -32768.0;
		return IN_W'($rtoi(t));
	endfunction

	function automatic logic signed [IN_W-1:0] corner_value();
		case ($urandom_range(0, 7))
			0: return IN_W'(MX);
			1: return IN_W'(MN);
			2: return '0;
			3: return IN_W'(ONE);
			4: return IN_W'(-ONE);
			5: return IN_W'(1);
			6: return IN_W'(-1);
			default: return IN_W'($urandom);
		endcase
	endfunction

	// A proper rotation built from a random axis and angle, quantised to Q2.14.
	function automatic pose_t random_rotation();
		real x, y, z, n, th, c, s, t;
		pose_t p;
		x = uniform_pm1();
		y = uniform_pm1();
		z = uniform_pm1();
		if ($urandom_range(0, 3) == 0) begin
			x = 0.0;
			y = 0.0;
			z = 0.0;
			case ($urandom_range(0, 2))
				0: x = ($urandom_range(0, 1) != 0) ? 1.0 : -1.0;
				1: y = ($urandom_range(0, 1) != 0) ? 1.0 : -1.0;
				default: z = ($urandom_range(0, 1) != 0) ? 1.0 : -1.0;
			endcase
		end
		n = $sqrt(x * x + y * y + z * z);
		if (n < 1.0e-3) begin
			x = 0.0;
			y = 0.0;
			z = 1.0;
			n = 1.0;
		end
		x = x / n;
		y = y / n;
		z = z / n;
		th = uniform_pm1() * 3.14159265358979;
		c = $cos(th);
		s = $sin(th);
		t = 1.0 - c;
		p.r00 = to_q2_14(c + t * x * x);
		p.r01 = to_q2_14(t * x * y - s * z);
		p.r02 = to_q2_14(t * x * z + s * y);
		p.r10 = to_q2_14(t * x * y + s * z);
		p.r11 = to_q2_14(c + t * y * y);
		p.r12 = to_q2_14(t * y * z - s * x);
		p.r20 = to_q2_14(t * x * z - s * y);
		p.r21 = to_q2_14(t * y * z + s * x);
		p.r22 = to_q2_14(c + t * z * z);
		p.ax = to_q2_14(x);
		p.ay = to_q2_14(y);
		p.az = to_q2_14(z);
		return p;
	endfunction

	function automatic pose_t random_pose(output bit is_rotation);
		pose_t p;
		int pick;
		int k;
		pick = $urandom_range(0, 99);
		is_rotation = 1'b0;
		if (pick < 45) begin
			p = random_rotation();
			is_rotation = 1'b1;
		end else if (pick < 55) begin
			// A rotation with one entry spoilt.
			p = random_rotation();
			k = $urandom_range(0, 11);
			p[16 * k +: 16] = IN_W'($urandom);
		end else if (pick < 75) begin
			p = pose_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		end else if (pick < 85) begin
			for (k = 0; k < 12; k++)
				p[16 * k +: 16] = IN_W'(int'($urandom_range(0, 8)) - 4);
		end else begin
			for (k = 0; k < 12; k++)
				p[16 * k +: 16] = corner_value();
		end
		return p;
	endfunction

	task automatic present(pose_t p);
		pose_bus.r00 <= p.r00;
		pose_bus.r01 <= p.r01;
		pose_bus.r02 <= p.r02;
		pose_bus.r10 <= p.r10;
		pose_bus.r11 <= p.r11;
		pose_bus.r12 <= p.r12;
		pose_bus.r20 <= p.r20;
		pose_bus.r21 <= p.r21;
		pose_bus.r22 <= p.r22;
		pose_bus.ax  <= p.ax;
		pose_bus.ay  <= p.ay;
		pose_bus.az  <= p.az;
	endtask

	// Offers one pose and files its angle once the beat has been taken.
	task automatic offer_pose(pose_t p, logic signed [ANG_W-1:0] want);
		int gap;
		gap = 0;
		if (!calm && ((poses_sent / 150) % 3 != 1) && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 12);
		if (gap > 0) begin
			pose_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pose_bus.valid <= 1'b1;
		present(p);
		do @(posedge clk); while (!pose_bus.ready);
		pending_angles.push_back(want);
		poses_sent++;
	endtask

	task automatic note_mismatch(string what, int want, int got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: expected angle %0d, got %0d", $realtime, what, want, got);
	endtask

	initial begin : stimulus
		pose_t p;
		bit is_rot;
		int i, k;
		logic signed [ANG_W-1:0] want;
		arst_n <= 1'b0;
		pose_bus.valid <= 1'b0;
		present('0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (i = 0; i < N_DIRECTED; i++) begin
			for (k = 0; k < 12; k++)
				p[16 * (11 - k) +: 16] = IN_W'(DIRECTED[i][k]);
			if (DIRECTED[i][12] == TYPED)
				want = ANG_W'(DIRECTED[i][13]);
			else
				want = angle_about_axis(p);
			offer_pose(p, want);
		end
		for (i = 0; i < N_RANDOM; i++) begin
			if (i >= N_RANDOM - CALM_TAIL)
				calm = 1'b1;
			p = random_pose(is_rot);
			if (is_rot)
				rotations_sent++;
			want = angle_about_axis(p);
			if (want == ANG_W'(PI_LIMIT) || want == -ANG_W'(PI_LIMIT))
				at_pi_limit++;
			offer_pose(p, want);
		end
		pose_bus.valid <= 1'b0;
		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d directed and %0d random poses (%0d proper rotations).",
			N_DIRECTED, N_RANDOM, rotations_sent);
		$display("Checked %0d angles, %0d at the +-pi limit, %0d mismatches.",
			angles_checked, at_pi_limit, mismatches);
		if (mismatches == 0 && pending_angles.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Receiver: random stalls, one long hold-off so the pipeline backs up, none at the end.
	initial begin : receiver
		angle_bus.ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (!held_off && !calm && angles_checked >= 200) begin
				held_off = 1'b1;
				angle_bus.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (!calm && ((angles_checked / 120) % 3 != 2)
					&& $urandom_range(0, 2) == 0) begin
				angle_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				angle_bus.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && angle_bus.valid && angle_bus.ready) begin
			angles_checked++;
			if (pending_angles.size() == 0)
				note_mismatch("angle beat with none pending", 0, int'(angle_bus.angle));
			else if (angle_bus.angle !== pending_angles[0])
				note_mismatch("angle mismatch", int'(pending_angles[0]),
					int'(angle_bus.angle));
			if (pending_angles.size() != 0)
				void'(pending_angles.pop_front());
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pose_bus.valid && pose_bus.ready) || (angle_bus.valid && angle_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles, %0d angles still pending.",
					quiet_cycles, pending_angles.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire
